FILE: hdl/zrewc_pkg.sv
// Shared constants and types for the zero-run expanding word checksum block.
`default_nettype none
package zrewc_pkg;

    localparam int TAIL_DEPTH      = 8;
    localparam int LINE_COUNT_BITS = 16;

    localparam int FILL_W     = $clog2(TAIL_DEPTH + 1);
    localparam int DROP_PLAIN = (6 < TAIL_DEPTH) ? 6 : TAIL_DEPTH;
    localparam int DROP_CRC   = (8 < TAIL_DEPTH) ? 8 : TAIL_DEPTH;

    localparam int WORD_W    = 16;
    localparam int RES_W     = 15;
    localparam int RES_CNT_W = 4;
    localparam int RUN_W     = 7;
    localparam int PAD_W     = 6;
    localparam int ADDR_W    = 5;
    localparam int APB_DW    = 32;

    localparam logic [RUN_W-1:0] RUN_EIGHT = 7'd64;
    localparam logic [RUN_W-1:0] RUN_FOUR  = 7'd32;
    localparam logic [RUN_W-1:0] RUN_TWO   = 7'd16;
    localparam logic [RUN_W-1:0] RUN_BYTE  = 7'd8;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT_LINE,
        ST_PAD_PAST,
        ST_ODD_BITS
    } t_status;

    typedef enum logic [2:0] {
        REG_COMPRESSED,
        REG_CRC,
        REG_CODE_EIGHT,
        REG_CODE_FOUR,
        REG_CODE_TWO,
        REG_PAD_BITS,
        REG_LINE_LIMIT
    } t_reg_idx;

endpackage
`default_nettype wire

FILE: hdl/zero_run_expand_word_checksum.sv
// A stream_end transfer gives its result in the output register on the next cycle.
// One byte per cycle while o_ready is high; expansion, padding skip and word add are combinational.
// Input stalls only for a stream_end byte while an untaken result holds the output register.
// Synchronous active-low reset restores register defaults and clears all stream state;
// the tail delay line is not cleared (entries are read only after being written in a line).
`default_nettype none
module zero_run_expand_word_checksum
    import zrewc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_line_end,
    input  wire logic              i_stream_end,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [WORD_W-1:0]      o_checksum,
    output logic [1:0]             o_status,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    logic                       r_compressed;
    logic                       r_crc;
    logic [7:0]                 r_code_eight;
    logic [7:0]                 r_code_four;
    logic [7:0]                 r_code_two;
    logic [PAD_W-1:0]           r_pad_bits;
    logic [15:0]                r_line_limit;

    logic [7:0]                 r_tail [TAIL_DEPTH];
    logic [FILL_W-1:0]          r_tail_fill;
    logic [PAD_W-1:0]           r_pad_left;
    logic [RES_W-1:0]           r_residue;
    logic [RES_CNT_W-1:0]       r_res_cnt;
    logic [WORD_W-1:0]          r_sum;
    logic [LINE_COUNT_BITS-1:0] r_lines_seen;
    t_status                    r_err;

    logic                       r_out_valid;
    logic [WORD_W-1:0]          r_checksum;
    t_status                    r_status;

    logic                       n_out_valid;
    logic [FILL_W-1:0]          n_tail_fill;
    logic [PAD_W-1:0]           n_pad_left;
    logic [RES_W-1:0]           n_residue;
    logic [RES_CNT_W-1:0]       n_res_cnt;
    logic [WORD_W-1:0]          n_sum;
    logic [LINE_COUNT_BITS-1:0] n_lines_seen;
    t_status                    n_err;

    logic                       in_xfer;
    logic                       cfg_wr;
    logic [FILL_W-1:0]          drop_cnt;
    logic [7:0]                 oldest;
    logic                       active;
    logic                       do_emit;
    logic [PAD_W-1:0]           pad_cur;
    logic [RUN_W-1:0]           zero_run;
    logic [RUN_W-1:0]           n_bits;
    logic [RUN_W-1:0]           skip;
    logic [RUN_W-1:0]           keep;
    logic [RUN_W-1:0]           total_z;
    logic [4:0]                 total_d;
    logic [2:0]                 sh_d;
    logic [30:0]                word_z;
    logic [22:0]                cat_d;
    logic [7:0]                 dmask;
    logic                       add_en;
    logic [WORD_W-1:0]          add_word;
    logic [FILL_W-1:0]          fill_inc;
    logic                       line_done;
    t_status                    err_mid;

    assign in_xfer = i_valid && o_ready;
    assign o_ready = !r_out_valid || i_ready || !i_stream_end;
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    assign o_valid    = r_out_valid;
    assign o_checksum = r_checksum;
    assign o_status   = r_status;

    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_COMPRESSED: prdata[0]       = r_compressed;
            REG_CRC:        prdata[0]       = r_crc;
            REG_CODE_EIGHT: prdata[7:0]     = r_code_eight;
            REG_CODE_FOUR:  prdata[7:0]     = r_code_four;
            REG_CODE_TWO:   prdata[7:0]     = r_code_two;
            REG_PAD_BITS:   prdata[PAD_W-1:0] = r_pad_bits;
            REG_LINE_LIMIT: prdata[15:0]    = r_line_limit;
            default:        prdata          = '0;
        endcase
    end

    always_comb begin
        drop_cnt = r_crc ? FILL_W'(DROP_CRC) : FILL_W'(DROP_PLAIN);
        oldest   = r_crc ? r_tail[DROP_CRC-1] : r_tail[DROP_PLAIN-1];
        active   = 32'(r_lines_seen) < 32'(r_line_limit);
        pad_cur  = (r_tail_fill == '0) ? r_pad_bits : r_pad_left;
        do_emit  = active && (r_tail_fill >= drop_cnt) && (r_err == ST_OK);

        zero_run = '0;
        if (r_compressed) begin
            if (oldest == r_code_eight)     zero_run = RUN_EIGHT;
            else if (oldest == r_code_four) zero_run = RUN_FOUR;
            else if (oldest == r_code_two)  zero_run = RUN_TWO;
        end
        n_bits = (zero_run != '0) ? zero_run : RUN_BYTE;
        skip   = ({1'b0, pad_cur} < n_bits) ? {1'b0, pad_cur} : n_bits;
        keep   = n_bits - skip;

        // zero run: at most one word can hold non-zero residue bits
        total_z = {3'b0, r_res_cnt} + keep;
        word_z  = {16'b0, r_residue} << (5'd16 - {1'b0, r_res_cnt});

        // plain byte: low keep bits of the byte join the residue
        dmask   = 8'(~(9'h1FF << keep[3:0]));
        cat_d   = ({8'b0, r_residue} << keep[3:0]) | {15'b0, oldest & dmask};
        total_d = {1'b0, r_res_cnt} + keep[4:0];
        sh_d    = 3'(total_d - 5'd16);

        n_pad_left = pad_cur;
        n_residue  = r_residue;
        n_res_cnt  = r_res_cnt;
        add_en     = 1'b0;
        add_word   = '0;
        if (do_emit) begin
            n_pad_left = pad_cur - skip[PAD_W-1:0];
            if (zero_run != '0) begin
                if (total_z >= RUN_W'(WORD_W)) begin
                    add_en    = 1'b1;
                    add_word  = word_z[WORD_W-1:0];
                    n_residue = '0;
                end else begin
                    n_residue = r_residue << keep[3:0];
                end
                n_res_cnt = total_z[RES_CNT_W-1:0];
            end else begin
                if (total_d >= 5'd16) begin
                    add_en    = 1'b1;
                    add_word  = 16'(cat_d >> sh_d);
                    n_residue = 15'(cat_d & ~(23'h7FFFFF << sh_d));
                    n_res_cnt = {1'b0, sh_d};
                end else begin
                    n_residue = cat_d[RES_W-1:0];
                    n_res_cnt = total_d[RES_CNT_W-1:0];
                end
            end
        end
        n_sum = add_en ? r_sum + add_word : r_sum;

        fill_inc = r_tail_fill;
        if (active && (r_tail_fill < FILL_W'(TAIL_DEPTH))) begin
            fill_inc = r_tail_fill + 1'b1;
        end

        line_done    = i_line_end || i_stream_end;
        err_mid      = r_err;
        n_tail_fill  = fill_inc;
        n_lines_seen = r_lines_seen;
        if (line_done) begin
            if (active && (r_err == ST_OK)) begin
                if (fill_inc < drop_cnt)     err_mid = ST_SHORT_LINE;
                else if (n_pad_left != '0)   err_mid = ST_PAD_PAST;
            end
            if (r_lines_seen != '1) begin
                n_lines_seen = r_lines_seen + 1'b1;
            end
            n_tail_fill = '0;
        end

        n_err = err_mid;
        if (i_stream_end && (err_mid == ST_OK) && (n_res_cnt != '0)) begin
            n_err = ST_ODD_BITS;
        end

        n_out_valid = r_out_valid && !i_ready;
        if (in_xfer && i_stream_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compressed <= 1'b0;
            r_crc        <= 1'b0;
            r_code_eight <= 8'hFF;
            r_code_four  <= 8'hFF;
            r_code_two   <= 8'hFF;
            r_pad_bits   <= '0;
            r_line_limit <= 16'hFFFF;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[ADDR_W-1:2]))
                REG_COMPRESSED: r_compressed <= pwdata[0];
                REG_CRC:        r_crc        <= pwdata[0];
                REG_CODE_EIGHT: r_code_eight <= pwdata[7:0];
                REG_CODE_FOUR:  r_code_four  <= pwdata[7:0];
                REG_CODE_TWO:   r_code_two   <= pwdata[7:0];
                REG_PAD_BITS:   r_pad_bits   <= pwdata[PAD_W-1:0];
                REG_LINE_LIMIT: r_line_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && active) begin
            r_tail[0] <= i_data_byte;
            for (int k = 1; k < TAIL_DEPTH; k++) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_fill  <= '0;
            r_pad_left   <= '0;
            r_residue    <= '0;
            r_res_cnt    <= '0;
            r_sum        <= '0;
            r_lines_seen <= '0;
            r_err        <= ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_xfer) begin
                if (i_stream_end) begin
                    r_tail_fill  <= '0;
                    r_pad_left   <= r_pad_bits;
                    r_residue    <= '0;
                    r_res_cnt    <= '0;
                    r_sum        <= '0;
                    r_lines_seen <= '0;
                    r_err        <= ST_OK;
                end else begin
                    r_tail_fill  <= n_tail_fill;
                    r_pad_left   <= n_pad_left;
                    r_residue    <= n_residue;
                    r_res_cnt    <= n_res_cnt;
                    r_sum        <= n_sum;
                    r_lines_seen <= n_lines_seen;
                    r_err        <= n_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_stream_end) begin
            r_checksum <= (n_err == ST_OK) ? n_sum : '0;
            r_status   <= n_err;
        end
    end

`ifndef SYNTHESIS
    a_residue_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_residue >> r_res_cnt) == '0)
        else $error("residue holds bits beyond its count");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_fill <= FILL_W'(TAIL_DEPTH))
        else $error("tail fill beyond delay depth");

    a_err_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |-> (r_checksum == '0))
        else $error("checksum not cleared on error");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_stream_end) |=> r_out_valid)
        else $error("stream end transfer without result");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_err != ST_OK) && !(in_xfer && i_stream_end)) |=> (r_err == $past(r_err)))
        else $error("error code changed mid stream");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for zero_run_expand_word_checksum: byte-stream predictor, result check.
module tb_top
    import zrewc_pkg::*;
();

    localparam int BYTE_TARGET   = 1800;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [WORD_W-1:0] checksum;
        t_status           status;
    } t_sum_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_ready;
    logic [7:0]        i_data_byte  = 8'h00;
    logic              i_line_end   = 1'b0;
    logic              i_stream_end = 1'b0;
    logic              o_valid;
    logic              i_ready      = 1'b0;
    logic [WORD_W-1:0] o_checksum;
    logic [1:0]        o_status;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [APB_DW-1:0] pwdata       = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // shadow of the configuration registers
    logic                 cfg_compressed = 1'b0;
    logic                 cfg_crc        = 1'b0;
    logic [7:0]           cfg_code8      = 8'hFF;
    logic [7:0]           cfg_code4      = 8'hFF;
    logic [7:0]           cfg_code2      = 8'hFF;
    logic [PAD_W-1:0]     cfg_pad        = '0;
    logic [15:0]          cfg_limit      = 16'hFFFF;

    // predicted stream state
    logic [7:0]                 tail_q [TAIL_DEPTH];
    int unsigned                tail_fill;
    logic [PAD_W-1:0]           pad_left;
    logic [RES_W-1:0]           residue;
    int unsigned                residue_cnt;
    logic [WORD_W-1:0]          word_sum;
    logic [LINE_COUNT_BITS-1:0] lines_seen;
    t_status                    stream_err;

    t_sum_result pending_sums [$];
    int          mismatches = 0;
    int          bytes_sent = 0;
    logic        steady     = 1'b0;

    zero_run_expand_word_checksum u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_line_end  (i_line_end),
        .i_stream_end(i_stream_end),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_checksum  (o_checksum),
        .o_status    (o_status),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_stream();
        tail_fill   = 0;
        pad_left    = cfg_pad;
        residue     = '0;
        residue_cnt = 0;
        word_sum    = '0;
        lines_seen  = '0;
        stream_err  = ST_OK;
    endfunction

    function automatic void feed_bit(input logic b);
        if (pad_left != 0) begin
            pad_left = pad_left - 1'b1;
        end else if (residue_cnt == WORD_W - 1) begin
            word_sum    = word_sum + {residue, b};
            residue     = '0;
            residue_cnt = 0;
        end else begin
            residue     = {residue[RES_W-2:0], b};
            residue_cnt = residue_cnt + 1;
        end
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        int unsigned zeros;
        zeros = 0;
        if (cfg_compressed) begin
            if (b == cfg_code8) begin
                zeros = RUN_EIGHT;
            end else if (b == cfg_code4) begin
                zeros = RUN_FOUR;
            end else if (b == cfg_code2) begin
                zeros = RUN_TWO;
            end
        end
        if (zeros != 0) begin
            repeat (zeros) feed_bit(1'b0);
        end else begin
            for (int i = 7; i >= 0; i--) feed_bit(b[i]);
        end
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic le, input logic se);
        int unsigned drop;
        logic        counted;
        t_sum_result res;
        drop    = cfg_crc ? DROP_CRC : DROP_PLAIN;
        counted = lines_seen < cfg_limit;
        if (tail_fill == 0) begin
            pad_left = cfg_pad;
        end
        if (counted) begin
            if (tail_fill >= drop && stream_err == ST_OK) begin
                feed_byte(tail_q[drop-1]);
            end
            for (int i = TAIL_DEPTH - 1; i > 0; i--) tail_q[i] = tail_q[i-1];
            tail_q[0] = b;
            if (tail_fill < TAIL_DEPTH) begin
                tail_fill = tail_fill + 1;
            end
        end
        if (le || se) begin
            if (counted && stream_err == ST_OK) begin
                if (tail_fill < drop) begin
                    stream_err = ST_SHORT_LINE;
                end else if (pad_left != 0) begin
                    stream_err = ST_PAD_PAST;
                end
            end
            if (lines_seen != '1) begin
                lines_seen = lines_seen + 1'b1;
            end
            tail_fill = 0;
        end
        if (se) begin
            if (stream_err == ST_OK && residue_cnt != 0) begin
                stream_err = ST_ODD_BITS;
            end
            res.status   = stream_err;
            res.checksum = (stream_err == ST_OK) ? word_sum : '0;
            pending_sums = {pending_sums, res};
            clear_stream();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_sum_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch($sformatf("unrequested result: checksum %h status %0d",
                                          o_checksum, o_status));
            end else begin
                want = pending_sums.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, predicted %0d",
                                              o_status, want.status));
                end
                if (o_checksum !== want.checksum) begin
                    report_mismatch($sformatf("checksum %h, predicted %h",
                                              o_checksum, want.checksum));
                end
            end
        end
        i_ready <= steady || ($urandom_range(99) >= 18);
    end

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_COMPRESSED: cfg_compressed = val[0];
            REG_CRC:        cfg_crc        = val[0];
            REG_CODE_EIGHT: cfg_code8      = val[7:0];
            REG_CODE_FOUR:  cfg_code4      = val[7:0];
            REG_CODE_TWO:   cfg_code2      = val[7:0];
            REG_PAD_BITS:   cfg_pad        = val[PAD_W-1:0];
            REG_LINE_LIMIT: cfg_limit      = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic le, input logic se);
        if (!steady && $urandom_range(99) < 12) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_line_end   <= le;
        i_stream_end <= se;
        do @(posedge i_clk); while (!o_ready);
        track_byte(b, le, se);
        bytes_sent++;
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom);
        while (cfg_compressed && (b == cfg_code8 || b == cfg_code4 || b == cfg_code2)) begin
            b = 8'($urandom);
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(2))
            0:       return cfg_code8;
            1:       return cfg_code4;
            default: return cfg_code2;
        endcase
    endfunction

    // lines whose surviving bits cover the padding; with padding a multiple of 16 they come out in whole words
    task automatic send_formed_stream(input int n_lines);
        logic [7:0]  body [$];
        int unsigned plain_n;
        logic        le;
        for (int ln = 0; ln < n_lines; ln++) begin
            body    = {};
            plain_n = 0;
            repeat ((cfg_pad + 7) / 8 + 2 * $urandom_range(0, 5)) begin
                if (cfg_compressed && $urandom_range(99) < 30) begin
                    body = {body, pick_code()};
                end else begin
                    body = {body, pick_plain()};
                    plain_n++;
                end
            end
            if (plain_n % 2 != 0) begin
                body = {body, pick_plain()};
            end
            repeat (cfg_crc ? DROP_CRC : DROP_PLAIN) body = {body, 8'($urandom)};
            for (int k = 0; k < body.size(); k++) begin
                le = (k == body.size() - 1) &&
                     (ln != n_lines - 1 || $urandom_range(1) == 1);
                send_byte(body[k], le, (k == body.size() - 1) && (ln == n_lines - 1));
            end
        end
    endtask

    task automatic send_noise_stream();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(1, 24);
        for (int k = 0; k < n; k++) begin
            b = (cfg_compressed && $urandom_range(99) < 25) ? pick_code() : 8'($urandom);
            send_byte(b, $urandom_range(99) < 15, k == n - 1);
        end
    endtask

    task automatic randomise_config();
        logic [7:0] c;
        write_reg(REG_COMPRESSED, {$urandom} & ~32'h1 | 32'($urandom_range(99) < 70));
        write_reg(REG_CRC, {$urandom} & ~32'h1 | 32'($urandom_range(1)));
        c = 8'($urandom);
        write_reg(REG_CODE_EIGHT, {$urandom} & ~32'hFF | 32'(c));
        if ($urandom_range(99) < 20) begin
            write_reg(REG_CODE_FOUR, 32'(c));
        end else begin
            write_reg(REG_CODE_FOUR, {$urandom} & ~32'hFF | 32'(8'($urandom)));
        end
        c = ($urandom_range(1) == 1) ? 8'($urandom) : {8{$urandom_range(1) == 1}};
        write_reg(REG_CODE_TWO, 32'(c));
        if ($urandom_range(99) < 65) begin
            write_reg(REG_PAD_BITS, 32'(16 * $urandom_range(0, 3)));
        end else if ($urandom_range(99) < 20) begin
            write_reg(REG_PAD_BITS, {$urandom} | 32'h3F);
        end else begin
            write_reg(REG_PAD_BITS, 32'($urandom_range(0, 63)));
        end
        case ($urandom_range(9))
            0, 1:    write_reg(REG_LINE_LIMIT, 32'($urandom_range(0, 3)));
            2:       write_reg(REG_LINE_LIMIT, $urandom);
            default: write_reg(REG_LINE_LIMIT, {$urandom} | 32'hFFFF);
        endcase
    endtask

    task automatic test_plain_words();
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        repeat (DROP_PLAIN - 1) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1, 1'b1);
        wait_results();
    endtask

    task automatic test_short_line();
        send_byte(8'h5A, 1'b1, 1'b1);
        wait_results();
    endtask

    // padding runs past the line; the short line after it must not replace the error
    task automatic test_pad_past_sticky();
        write_reg(REG_PAD_BITS, 32'd40);
        repeat (DROP_PLAIN) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        wait_results();
    endtask

    // zero runs, full padding, odd leftover bits, second line beyond the limit
    task automatic test_zero_runs_limit();
        write_reg(REG_COMPRESSED, 32'd1);
        write_reg(REG_CODE_EIGHT, 32'h00);
        write_reg(REG_CODE_FOUR, 32'hFF);
        write_reg(REG_CODE_TWO, 32'h80);
        write_reg(REG_PAD_BITS, 32'd63);
        write_reg(REG_LINE_LIMIT, 32'd1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        repeat (DROP_PLAIN - 1) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b1);
        wait_results();
    endtask

    task automatic test_random_streams();
        int phase;
        phase = 0;
        while (bytes_sent < BYTE_TARGET) begin
            randomise_config();
            steady = (phase == 3);
            repeat ($urandom_range(3, 6)) begin
                if ($urandom_range(99) < 75) begin
                    send_formed_stream($urandom_range(1, 4));
                end else begin
                    send_noise_stream();
                end
                if ($urandom_range(99) < 10) begin
                    wait_results();
                end
            end
            wait_results();
            steady = 1'b0;
            phase++;
        end
    endtask

    initial begin
        clear_stream();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_words();
        test_short_line();
        test_pad_past_sticky();
        test_zero_runs_limit();
        test_random_streams();
        wait_results();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/zrewc_pkg.sv
hdl/zero_run_expand_word_checksum.sv
bench/tb_top.sv
